[design/blsc_pkg.sv]
// ----------------------------------------------------------------------------
// blsc_pkg
// Shared types, constants and saturating Q32.32 helpers for the line search.
// ----------------------------------------------------------------------------
`default_nettype none

package blsc_pkg;

  localparam int MAX_ITERATIONS_DEF = 100;

  // golden section fraction and one half in Q32.32
  localparam logic signed [63:0] Q_GOLD = 64'sd1640531527;
  localparam logic signed [63:0] Q_HALF = 64'sd2147483648;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  localparam logic [32:0] RELTOL_RESET = 33'd429497;
  localparam logic [32:0] ABSEPS_RESET = 33'd1;

  localparam logic OPC_START = 1'b0;
  localparam logic OPC_VALUE = 1'b1;

  localparam logic REG_RELTOL = 1'b0;
  localparam logic REG_ABSEPS = 1'b1;

  localparam logic [1:0] STAT_PROBE = 2'd0;
  localparam logic [1:0] STAT_CONV  = 2'd1;
  localparam logic [1:0] STAT_LIMIT = 2'd2;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  function automatic logic signed [63:0] clip65(input logic signed [64:0] s);
    logic signed [63:0] r;
    if (s[64] == s[63]) begin
      r = s[63:0];
    end else if (s[64]) begin
      r = S64_MIN;
    end else begin
      r = S64_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    return clip65(s);
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    return clip65(s);
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    logic signed [64:0] s;
    s = 65'sd0 - {a[63], a};
    return clip65(s);
  endfunction

  function automatic logic signed [63:0] sat_abs(input logic signed [63:0] a);
    logic signed [63:0] r;
    r = a[63] ? sat_neg(a) : a;
    return r;
  endfunction

  function automatic logic [63:0] umag(input logic signed [63:0] a);
    logic [63:0] r;
    r = a[63] ? (64'd0 - a) : a;
    return r;
  endfunction

  // sign and magnitude back to signed, clipped
  function automatic logic signed [63:0] sat_mag(input logic neg, input logic [63:0] mag,
                                                input logic over);
    logic signed [63:0] r;
    if (neg) begin
      r = (over || mag[63]) ? S64_MIN : (64'd0 - mag);
    end else begin
      r = (over || mag[63]) ? S64_MAX : mag;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/brent_line_search_controller.sv]
// ----------------------------------------------------------------------------
// brent_line_search_controller
// Brent 1-D minimization sequencer (parabolic / golden section) in Q32.32.
// ----------------------------------------------------------------------------
// A start request (tuser 0) loads the bracket and answers with the first probe.
// A value request (tuser 1) folds in the probed value and answers with the
// next probe, convergence or the iteration limit; the next probe comes from
// the golden-section step or, when it is tried and taken, the parabolic fit.
// A value request while the search is idle repeats the held status.
// Multiplies (four 32x32 partial products) and the bit-serial divide all run
// on the one shared arithmetic unit. One request is in work at a time;
// s_tready is low while the sequencer runs or a result is not taken.
`default_nettype none

module brent_line_search_controller #(
  parameter int MAX_ITERATIONS = blsc_pkg::MAX_ITERATIONS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // s_tdata: bracket_a, bracket_mid, bracket_c, mid_value, probe_value
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [319:0] s_tdata,
  // s_tuser: opcode
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata: probe_position, best_position, second_position, best_value
  output logic [255:0]      m_tdata,
  // m_tuser: status
  output logic [1:0]        m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam int ITW = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_S1, ST_S2, ST_VAL, ST_IT0, ST_TOLM, ST_TOL, ST_W, ST_CONV0, ST_CONV1,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9, ST_P10,
    ST_P11, ST_P12, ST_P13, ST_GOLD, ST_F0, ST_F1, ST_WAIT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    D_MID, D_T, D_R, D_Q, D_P, D_WL, D_WU, D_LS
  } dst_t;

  state_t state;
  state_t ret;
  dst_t   dst;

  logic [32:0] reltol;
  logic [32:0] abseps;

  logic signed [63:0] le, re, bp, sp, psp, bpv, spv, pspv, ls, sbl, pp;
  logic [ITW-1:0]     iter;
  logic               aw;
  logic               idle;
  logic [1:0]         fstat;
  logic [1:0]         fin;
  logic signed [63:0] fval;

  logic signed [63:0] mid, tol1, t2, wl, wu, r, q, p, t, u;

  logic signed [63:0] opa, opb;
  blsc_pkg::arith_req_t req;
  logic signed [63:0] ar_result;
  logic               ar_done;

  logic [1:0]   o_status;
  logic [63:0]  o_probe, o_best, o_second, o_bv;

  logic signed [63:0] in_a, in_mid, in_c, in_midv, in_probev;
  logic signed [63:0] sbl_gold;

  assign in_a      = s_tdata[63:0];
  assign in_mid    = s_tdata[127:64];
  assign in_c      = s_tdata[191:128];
  assign in_midv   = s_tdata[255:192];
  assign in_probev = s_tdata[319:256];

  assign sbl_gold = (bp < mid) ? blsc_pkg::sat_sub(re, bp) : blsc_pkg::sat_sub(le, bp);

  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign m_tdata  = {o_bv, o_second, o_best, o_probe};
  assign m_tuser  = o_status;
  assign pready   = 1'b1;

  always_comb begin
    unique case (paddr[3])
      blsc_pkg::REG_RELTOL: prdata = {31'd0, reltol};
      default:              prdata = {31'd0, abseps};
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reltol <= blsc_pkg::RELTOL_RESET;
      abseps <= blsc_pkg::ABSEPS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        blsc_pkg::REG_RELTOL: reltol <= pwdata[32:0];
        default:              abseps <= pwdata[32:0];
      endcase
    end
  end

  blsc_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (opa),
    .b      (opb),
    .result (ar_result),
    .done   (ar_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      dst       <= D_T;
      req.start <= 1'b0;
      req.op    <= blsc_pkg::OP_MUL;
      m_tvalid  <= 1'b0;
      le <= '0; re <= '0; bp <= '0; sp <= '0; psp <= '0;
      bpv <= '0; spv <= '0; pspv <= '0; ls <= '0; sbl <= '0; pp <= '0;
      iter  <= '0;
      aw    <= 1'b0;
      idle  <= 1'b1;
      fstat <= blsc_pkg::STAT_CONV;
      fin   <= blsc_pkg::STAT_PROBE;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (s_tuser[0] == blsc_pkg::OPC_START) begin
              le    <= (in_a < in_c) ? in_a : in_c;
              re    <= (in_a > in_c) ? in_a : in_c;
              bp    <= in_mid;
              bpv   <= in_midv;
              state <= ST_S1;
            end else if (idle) begin
              fin   <= fstat;
              state <= ST_DONE;
            end else begin
              fval  <= in_probev;
              state <= ST_VAL;
            end
          end
        end
        ST_S1: begin
          opa <= blsc_pkg::Q_GOLD; opb <= blsc_pkg::sat_sub(re, le);
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_T; ret <= ST_S2; state <= ST_WAIT;
        end
        ST_S2: begin
          sp   <= blsc_pkg::sat_add(le, t);
          psp  <= blsc_pkg::sat_add(le, t);
          pp   <= blsc_pkg::sat_add(le, t);
          spv  <= '0; pspv <= '0; ls <= '0; sbl <= '0;
          iter <= '0; aw <= 1'b1; idle <= 1'b0;
          fin  <= blsc_pkg::STAT_PROBE;
          state <= ST_DONE;
        end
        ST_VAL: begin
          if (aw) begin
            spv  <= fval;
            pspv <= fval;
            aw   <= 1'b0;
          end else if (fval > bpv) begin
            if (pp < bp) begin
              le <= pp;
            end else begin
              re <= pp;
            end
            if (fval <= spv || sp == bp) begin
              psp  <= sp;
              pspv <= spv;
              sp   <= pp;
              spv  <= fval;
            end else if (fval <= pspv || psp == bp || psp == sp) begin
              psp  <= pp;
              pspv <= fval;
            end
          end else begin
            if (pp < bp) begin
              re <= bp;
            end else begin
              le <= bp;
            end
            psp  <= sp;
            pspv <= spv;
            sp   <= bp;
            spv  <= bpv;
            bp   <= pp;
            bpv  <= fval;
          end
          state <= ST_IT0;
        end
        ST_IT0: begin
          if (iter >= ITW'(MAX_ITERATIONS)) begin
            fin   <= blsc_pkg::STAT_LIMIT;
            state <= ST_DONE;
          end else begin
            iter <= iter + 1'b1;
            opa  <= blsc_pkg::Q_HALF; opb <= blsc_pkg::sat_add(le, re);
            req  <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
            dst  <= D_MID; ret <= ST_TOLM; state <= ST_WAIT;
          end
        end
        ST_TOLM: begin
          opa <= {31'd0, reltol}; opb <= blsc_pkg::sat_abs(bp);
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_T; ret <= ST_TOL; state <= ST_WAIT;
        end
        ST_TOL: begin
          tol1  <= blsc_pkg::sat_add(t, {31'd0, abseps});
          state <= ST_W;
        end
        ST_W: begin
          t2  <= blsc_pkg::sat_add(tol1, tol1);
          wl  <= blsc_pkg::sat_sub(le, bp);
          wu  <= blsc_pkg::sat_sub(re, bp);
          opa <= blsc_pkg::Q_HALF; opb <= blsc_pkg::sat_sub(re, le);
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_T; ret <= ST_CONV0; state <= ST_WAIT;
        end
        ST_CONV0: begin
          t     <= blsc_pkg::sat_sub(t2, t);
          u     <= blsc_pkg::sat_sub(bp, mid);
          state <= ST_CONV1;
        end
        ST_CONV1: begin
          priority if (blsc_pkg::sat_abs(u) <= t) begin
            fin   <= blsc_pkg::STAT_CONV;
            state <= ST_DONE;
          end else if (blsc_pkg::sat_abs(sbl) > tol1) begin
            state <= ST_P0;
          end else begin
            state <= ST_GOLD;
          end
        end
        ST_P0: begin
          opa <= blsc_pkg::sat_sub(bp, sp); opb <= blsc_pkg::sat_sub(bpv, pspv);
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_R; ret <= ST_P1; state <= ST_WAIT;
        end
        ST_P1: begin
          opa <= blsc_pkg::sat_sub(bp, psp); opb <= blsc_pkg::sat_sub(bpv, spv);
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_Q; ret <= ST_P2; state <= ST_WAIT;
        end
        ST_P2: begin
          opa <= blsc_pkg::sat_sub(bp, psp); opb <= q;
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_P; ret <= ST_P3; state <= ST_WAIT;
        end
        ST_P3: begin
          opa <= blsc_pkg::sat_sub(bp, sp); opb <= r;
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_T; ret <= ST_P4; state <= ST_WAIT;
        end
        ST_P4: begin
          p     <= blsc_pkg::sat_sub(p, t);
          q     <= blsc_pkg::sat_sub(q, r);
          state <= ST_P5;
        end
        ST_P5: begin
          q     <= blsc_pkg::sat_add(q, q);
          state <= ST_P6;
        end
        ST_P6: begin
          if (q > 0) begin
            p <= blsc_pkg::sat_neg(p);
          end else begin
            q <= blsc_pkg::sat_neg(q);
          end
          r     <= sbl;
          sbl   <= ls;
          state <= ST_P7;
        end
        ST_P7: begin
          opa <= blsc_pkg::Q_HALF; opb <= q;
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_T; ret <= ST_P8; state <= ST_WAIT;
        end
        ST_P8: begin
          opa <= t; opb <= r;
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_T; ret <= ST_P9; state <= ST_WAIT;
        end
        ST_P9: begin
          opa <= q; opb <= wl;
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_WL; ret <= ST_P10; state <= ST_WAIT;
        end
        ST_P10: begin
          opa <= q; opb <= wu;
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_WU; ret <= ST_P11; state <= ST_WAIT;
        end
        ST_P11: begin
          if (blsc_pkg::sat_abs(p) < blsc_pkg::sat_abs(t) && p > wl && p < wu) begin
            opa <= p; opb <= q;
            req <= '{start: 1'b1, op: blsc_pkg::OP_DIV};
            dst <= D_LS; ret <= ST_P12; state <= ST_WAIT;
          end else begin
            state <= ST_GOLD;
          end
        end
        ST_P12: begin
          u     <= blsc_pkg::sat_add(bp, ls);
          state <= ST_P13;
        end
        ST_P13: begin
          // too close to a bracket end: step by tol1 toward the middle
          if (blsc_pkg::sat_sub(u, le) < t2 || blsc_pkg::sat_sub(re, u) < t2) begin
            ls <= (bp < mid) ? tol1 : blsc_pkg::sat_neg(tol1);
          end
          state <= ST_F0;
        end
        ST_GOLD: begin
          sbl <= sbl_gold;
          opa <= blsc_pkg::Q_GOLD; opb <= sbl_gold;
          req <= '{start: 1'b1, op: blsc_pkg::OP_MUL};
          dst <= D_LS; ret <= ST_F0; state <= ST_WAIT;
        end
        ST_F0: begin
          priority if (blsc_pkg::sat_abs(ls) >= tol1) begin
            t <= ls;
          end else if (ls > 0) begin
            t <= tol1;
          end else begin
            t <= blsc_pkg::sat_neg(tol1);
          end
          state <= ST_F1;
        end
        ST_F1: begin
          pp    <= blsc_pkg::sat_add(bp, t);
          fin   <= blsc_pkg::STAT_PROBE;
          state <= ST_DONE;
        end
        ST_WAIT: begin
          req.start <= 1'b0;
          if (ar_done) begin
            unique case (dst)
              D_MID:   mid  <= ar_result;
              D_T:     t    <= ar_result;
              D_R:     r    <= ar_result;
              D_Q:     q    <= ar_result;
              D_P:     p    <= ar_result;
              D_WL:    wl   <= ar_result;
              D_WU:    wu   <= ar_result;
              default: ls   <= ar_result;
            endcase
            state <= ret;
          end
        end
        default: begin
          m_tvalid <= 1'b1;
          o_status <= fin;
          o_probe  <= (fin == blsc_pkg::STAT_PROBE) ? pp : '0;
          o_best   <= bp;
          o_second <= sp;
          o_bv     <= bpv;
          if (fin != blsc_pkg::STAT_PROBE) begin
            idle  <= 1'b1;
            fstat <= fin;
          end
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/blsc_arith.sv]
// ----------------------------------------------------------------------------
// blsc_arith
// Shared multi-cycle Q32.32 multiplier (32x32 partial products) and
// bit-serial restoring divider, both saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module blsc_arith (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire blsc_pkg::arith_req_t req,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic signed [63:0]      result,
  output logic                    done
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIN
  } astate_t;

  astate_t      state;
  logic [63:0]  x;
  logic [63:0]  y;
  logic         neg;
  logic         is_div;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [6:0]   cnt;
  logic [95:0]  num;
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic         over;

  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [127:0] pp_sh;
  logic [63:0]  remsh;
  logic         ge;
  logic [127:0] rnd;

  always_comb begin
    unique case (cnt[1:0])
      2'd0: begin xs = x[31:0];  ys = y[31:0];  end
      2'd1: begin xs = x[31:0];  ys = y[63:32]; end
      2'd2: begin xs = x[63:32]; ys = y[31:0];  end
      default: begin xs = x[63:32]; ys = y[63:32]; end
    endcase
    // pp holds the product issued in the previous cycle
    priority if (cnt == 7'd1) begin
      pp_sh = {64'd0, pp};
    end else if (cnt == 7'd4) begin
      pp_sh = {pp, 64'd0};
    end else begin
      pp_sh = {32'd0, pp, 32'd0};
    end
    remsh = {rem[62:0], num[95]};
    ge    = remsh >= y;
    rnd   = acc + 128'h8000_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        A_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            x      <= blsc_pkg::umag(a);
            y      <= blsc_pkg::umag(b);
            neg    <= a[63] != b[63];
            is_div <= req.op == blsc_pkg::OP_DIV;
            acc    <= '0;
            cnt    <= '0;
            num    <= {blsc_pkg::umag(a), 32'd0};
            rem    <= '0;
            quo    <= '0;
            over   <= 1'b0;
            state  <= (req.op == blsc_pkg::OP_DIV) ? A_DIV : A_MUL;
          end
        end
        A_MUL: begin
          if (cnt < 7'd4) begin
            pp <= xs * ys;
          end
          if (cnt != 7'd0) begin
            acc <= acc + pp_sh;
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd4) begin
            state <= A_FIN;
          end
        end
        A_DIV: begin
          rem   <= ge ? (remsh - y) : remsh;
          quo   <= {quo[62:0], ge};
          over  <= over | quo[63];
          num   <= {num[94:0], 1'b0};
          cnt   <= cnt + 7'd1;
          if (cnt == 7'd95) begin
            state <= A_FIN;
          end
        end
        default: begin
          if (is_div) begin
            result <= blsc_pkg::sat_mag(neg, quo, over);
          end else begin
            result <= blsc_pkg::sat_mag(neg, rnd[95:32], |rnd[127:96]);
          end
          done  <= 1'b1;
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Brent line-search controller. Bracket starts and
// probe values go in on the input stream. Each answer is checked field by
// field against an in-bench Q32.32 copy of the search, or against a typed
// answer for the table rows that give one. Runs cover several tolerance
// settings, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import blsc_pkg::*;

  typedef logic signed [63:0] fx_t;

  typedef struct {
    logic op;
    fx_t  a, m, c, mv, pv;
  } request_t;

  typedef struct {
    logic [1:0] status;
    fx_t        probe, best, second, bval;
  } answer_t;

  typedef struct {
    request_t req;
    bit       typed;
    answer_t  ans;
  } row_t;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 250;
  localparam int PHASE_ITEMS = 300;

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [319:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid, m_tready;
  logic [255:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         psel, penable, pwrite, pready;
  logic [3:0]   paddr;
  logic [63:0]  pwdata, prdata;

  brent_line_search_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // search state mirror
  logic [32:0] tol_rel, tol_abs;
  fx_t  lo_end, hi_end, best_x, second_x, prev_x, best_f, second_f, prev_f;
  fx_t  step_last, step_prior, next_probe;
  int   iter_n;
  bit   first_pending, search_idle;
  logic [1:0] held_status;

  answer_t pending_answers[$];
  int   errors = 0;
  int   sent = 0;
  int   answers_seen = 0;
  int   cycles = 0;
  bit   tx_no_gap = 0;
  bit   rx_no_gap = 0;
  bit   long_hold_done = 0;

  // objective used by well-formed searches
  fx_t  obj_center, obj_curv, obj_offset;
  int   obj_shape;

  function automatic fx_t clip(input logic signed [64:0] s);
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return S64_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    return clip(s);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    return clip(s);
  endfunction

  function automatic fx_t fx_neg(input fx_t a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic fx_t fx_abs(input fx_t a);
    return (a < 0) ? fx_neg(a) : a;
  endfunction

  function automatic fx_t from_mag(input bit ng, input logic [63:0] m, input bit over);
    if (over || m[63]) return ng ? S64_MIN : S64_MAX;
    return ng ? -fx_t'(m) : fx_t'(m);
  endfunction

  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    logic [63:0]  x, y;
    logic [127:0] p;
    x = a[63] ? 64'd0 - a : a;
    y = b[63] ? 64'd0 - b : b;
    p = {64'd0, x} * {64'd0, y};
    p = p + (128'd1 << 31);
    return from_mag(a[63] ^ b[63], p[95:32], p[127:96] != 0);
  endfunction

  // shift-subtract on a 64-bit remainder, top bit dropped on each shift
  function automatic fx_t fx_div(input fx_t p, input fx_t q);
    logic [63:0]  m, d, rem, quo;
    logic [127:0] num;
    bit           over;
    if (q == 0) return (p < 0) ? S64_MIN : S64_MAX;
    m = p[63] ? 64'd0 - p : p;
    d = q[63] ? 64'd0 - q : q;
    num = {32'd0, m, 32'd0};
    rem = '0;
    quo = '0;
    over = 0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (quo[63]) over = 1;
      quo = {quo[62:0], 1'b0};
      if (rem >= d) begin
        rem = rem - d;
        quo[0] = 1'b1;
      end
    end
    return from_mag(p[63] ^ q[63], quo, over);
  endfunction

  function automatic void golden_step(input fx_t z, input fx_t mid);
    step_prior = (z < mid) ? fx_sub(hi_end, z) : fx_sub(lo_end, z);
    step_last = fx_mul(Q_GOLD, step_prior);
  endfunction

  function automatic void fold_value(input fx_t fu);
    fx_t u;
    u = next_probe;
    if (fu > best_f) begin
      if (u < best_x) lo_end = u;
      else hi_end = u;
      if (fu <= second_f || second_x == best_x) begin
        prev_x = second_x;
        prev_f = second_f;
        second_x = u;
        second_f = fu;
      end else if (fu <= prev_f || prev_x == best_x || prev_x == second_x) begin
        prev_x = u;
        prev_f = fu;
      end
    end else begin
      if (u < best_x) hi_end = best_x;
      else lo_end = best_x;
      prev_x = second_x;
      prev_f = second_f;
      second_x = best_x;
      second_f = best_f;
      best_x = u;
      best_f = fu;
    end
  endfunction

  // iteration limit and convergence tests, then the next probe
  function automatic logic [1:0] search_step();
    fx_t z, tol1, t2, mid, wl, wu, d, u, p, q, r;
    z = best_x;
    if (iter_n >= MAX_ITERATIONS_DEF) return STAT_LIMIT;
    iter_n++;
    mid = fx_mul(Q_HALF, fx_add(lo_end, hi_end));
    tol1 = fx_add(fx_mul(fx_t'(tol_rel), fx_abs(z)), fx_t'(tol_abs));
    t2 = fx_add(tol1, tol1);
    wl = fx_sub(lo_end, z);
    wu = fx_sub(hi_end, z);
    if (fx_abs(fx_sub(z, mid)) <= fx_sub(t2, fx_mul(Q_HALF, fx_sub(hi_end, lo_end))))
      return STAT_CONV;
    if (fx_abs(step_prior) > tol1) begin
      r = fx_mul(fx_sub(z, second_x), fx_sub(best_f, prev_f));
      q = fx_mul(fx_sub(z, prev_x), fx_sub(best_f, second_f));
      p = fx_sub(fx_mul(fx_sub(z, prev_x), q), fx_mul(fx_sub(z, second_x), r));
      q = fx_sub(q, r);
      q = fx_add(q, q);
      if (q > 0) p = fx_neg(p);
      else q = fx_neg(q);
      r = step_prior;
      step_prior = step_last;
      if (fx_abs(p) < fx_abs(fx_mul(fx_mul(Q_HALF, q), r)) &&
          p > fx_mul(q, wl) && p < fx_mul(q, wu)) begin
        step_last = fx_div(p, q);
        u = fx_add(z, step_last);
        if (fx_sub(u, lo_end) < t2 || fx_sub(hi_end, u) < t2)
          step_last = (z < mid) ? tol1 : fx_neg(tol1);
      end else begin
        golden_step(z, mid);
      end
    end else begin
      golden_step(z, mid);
    end
    d = step_last;
    if (fx_abs(d) >= tol1) u = fx_add(z, d);
    else u = fx_add(z, (d > 0) ? tol1 : fx_neg(tol1));
    next_probe = u;
    return STAT_PROBE;
  endfunction

  function automatic answer_t brent_advance(input request_t rq);
    answer_t ans;
    logic [1:0] st;
    if (rq.op == OPC_START) begin
      lo_end = (rq.a < rq.c) ? rq.a : rq.c;
      hi_end = (rq.a > rq.c) ? rq.a : rq.c;
      best_x = rq.m;
      best_f = rq.mv;
      second_x = fx_add(lo_end, fx_mul(Q_GOLD, fx_sub(hi_end, lo_end)));
      prev_x = second_x;
      second_f = 0;
      prev_f = 0;
      step_last = 0;
      step_prior = 0;
      next_probe = second_x;
      iter_n = 0;
      first_pending = 1;
      search_idle = 0;
      st = STAT_PROBE;
    end else if (search_idle) begin
      st = held_status;
    end else begin
      if (first_pending) begin
        second_f = rq.pv;
        prev_f = rq.pv;
        first_pending = 0;
      end else begin
        fold_value(rq.pv);
      end
      st = search_step();
      if (st != STAT_PROBE) begin
        search_idle = 1;
        held_status = st;
      end
    end
    ans.status = st;
    ans.probe = (st == STAT_PROBE) ? next_probe : 0;
    ans.best = best_x;
    ans.second = second_x;
    ans.bval = best_f;
    return ans;
  endfunction

  function automatic fx_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic fx_t rand_pos(input int span);
    return (fx_t'(int'($urandom_range(0, 2 * span)) - span) <<< 32) + fx_t'($urandom);
  endfunction

  function automatic fx_t objective(input fx_t x);
    fx_t dx;
    dx = fx_sub(x, obj_center);
    case (obj_shape)
      0: return fx_add(fx_mul(obj_curv, fx_mul(dx, dx)), obj_offset);
      1: return fx_add(fx_mul(obj_curv, fx_abs(dx)), obj_offset);
      default: return fx_add(fx_mul(obj_curv, fx_mul(dx, dx)),
                             fx_t'($urandom_range(0, 1 << 16)));
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("brent_line_search_controller regression: fail");
      $finish;
    end
  end

  task automatic check_field(input string name, input fx_t exp_v, input fx_t got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin : answer_check
    answer_t e;
    if (!rst && m_tvalid && m_tready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t unexpected answer: expected none actual status %0d probe %h",
                 $time, m_tuser, m_tdata[63:0]);
      end else begin
        e = pending_answers.pop_front();
        check_field("status", fx_t'(e.status), fx_t'(m_tuser));
        check_field("probe_position", e.probe, m_tdata[63:0]);
        check_field("best_position", e.best, m_tdata[127:64]);
        check_field("second_position", e.second, m_tdata[191:128]);
        check_field("best_value", e.bval, m_tdata[255:192]);
      end
    end
  end

  // answer side: random stalls plus one long hold-off
  initial begin : answer_sink
    int w;
    m_tready = 0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_no_gap = !rx_no_gap;
      if (!long_hold_done && answers_seen >= 150) begin
        long_hold_done = 1;
        m_tready <= 0;
        repeat (3000) @(posedge clk);
        m_tready <= 1;
      end else begin
        w = rx_no_gap ? 0 : $urandom_range(0, 5);
        if (w > 0) begin
          m_tready <= 0;
          repeat (w) @(posedge clk);
        end
        m_tready <= 1;
      end
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_request(input request_t rq, input bit typed, input answer_t typed_ans);
    int w;
    answer_t a;
    if ($urandom_range(0, 63) == 0) tx_no_gap = !tx_no_gap;
    w = tx_no_gap ? 0 : $urandom_range(0, 5);
    if (w > 0) begin
      s_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    s_tdata <= {rq.pv, rq.mv, rq.c, rq.m, rq.a};
    s_tuser <= rq.op;
    s_tvalid <= 1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    a = brent_advance(rq);
    if (typed) a = typed_ans;
    pending_answers.push_back(a);
    sent++;
  endtask

  task automatic apb_write(input logic idx, input logic [32:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 3'b000};
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_RELTOL) tol_rel = value;
    else tol_abs = value;
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one search on a known objective, sometimes cut short by a restart
  task automatic run_search();
    request_t rq;
    answer_t none;
    fx_t lo, hi, mid;
    none = '{default: 0};
    obj_center = rand_pos(100);
    obj_curv = fx_t'($urandom_range(1, 16)) <<< 29;
    obj_offset = rand_pos(1000);
    obj_shape = $urandom_range(0, 2);
    lo = fx_sub(obj_center, rand_pos(20) + (fx_t'(21) <<< 32));
    hi = fx_add(obj_center, ($urandom_range(0, 3) == 0) ? fx_t'($urandom) :
                rand_pos(20) + (fx_t'(21) <<< 32));
    mid = fx_add(obj_center, fx_t'(int'($urandom_range(0, 2000)) - 1000) <<< 20);
    rq.op = OPC_START;
    rq.a = $urandom_range(0, 1) ? lo : hi;
    rq.c = (rq.a == lo) ? hi : lo;
    rq.m = mid;
    rq.mv = objective(mid);
    rq.pv = rand_word();
    send_request(rq, 0, none);
    while (!search_idle) begin
      if ($urandom_range(0, 39) == 0) return;
      rq.op = OPC_VALUE;
      rq.a = rand_word();
      rq.m = rand_word();
      rq.c = rand_word();
      rq.mv = rand_word();
      rq.pv = objective(next_probe);
      send_request(rq, 0, none);
    end
    if ($urandom_range(0, 3) == 0) begin
      rq.pv = rand_word();
      send_request(rq, 0, none);
    end
  endtask

  task automatic random_traffic(input int target);
    request_t rq;
    answer_t none;
    none = '{default: 0};
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        rq.op = $urandom_range(0, 1) ? OPC_VALUE : OPC_START;
        rq.a = rand_word();
        rq.m = rand_word();
        rq.c = rand_word();
        rq.mv = rand_word();
        rq.pv = rand_word();
        send_request(rq, 0, none);
      end else begin
        run_search();
      end
    end
  endtask

  function automatic row_t mk_row(input logic op, input fx_t a, input fx_t m, input fx_t c,
                                  input fx_t mv, input fx_t pv);
    row_t r;
    r.req = '{op: op, a: a, m: m, c: c, mv: mv, pv: pv};
    r.typed = 0;
    r.ans = '{default: 0};
    return r;
  endfunction

  initial begin : stimulus
    row_t table_rows[$];
    row_t r;
    fx_t one;
    one = fx_t'(1) <<< 32;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    tol_rel = RELTOL_RESET;
    tol_abs = ABSEPS_RESET;
    lo_end = 0; hi_end = 0; best_x = 0; second_x = 0; prev_x = 0;
    best_f = 0; second_f = 0; prev_f = 0;
    step_last = 0; step_prior = 0; next_probe = 0;
    iter_n = 0;
    first_pending = 0;
    search_idle = 1;
    held_status = STAT_CONV;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // value right after reset repeats the held converged report
    r = mk_row(OPC_VALUE, 0, 0, 0, 0, one);
    r.typed = 1;
    r.ans = '{status: STAT_CONV, probe: 0, best: 0, second: 0, bval: 0};
    table_rows.push_back(r);
    // zero-width bracket: first probe sits on the bracket
    r = mk_row(OPC_START, 0, 0, 0, 5 * one, 0);
    r.typed = 1;
    r.ans = '{status: STAT_PROBE, probe: 0, best: 0, second: 0, bval: 5 * one};
    table_rows.push_back(r);
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, 0));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, S64_MAX));
    // full-range bracket with extreme values
    table_rows.push_back(mk_row(OPC_START, S64_MIN, 0, S64_MAX, S64_MIN, 0));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, S64_MAX));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, S64_MIN));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, 0));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, S64_MAX));
    // unordered bracket ends
    table_rows.push_back(mk_row(OPC_START, 10 * one, one, -10 * one, 0, 0));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, one));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, -one));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, 2 * one));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, -2 * one));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, 3 * one));
    // restart in the middle of a search
    table_rows.push_back(mk_row(OPC_START, S64_MAX, S64_MAX, S64_MIN, S64_MAX, 0));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, S64_MAX));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, S64_MIN));
    table_rows.push_back(mk_row(OPC_START, -one, 0, one, 0, 0));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, one >>> 4));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, -1));
    table_rows.push_back(mk_row(OPC_VALUE, 0, 0, 0, 0, 1));
    foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].typed,
                                         table_rows[i].ans);
    random_traffic(PHASE_ITEMS);

    // tolerances at zero: searches run into the iteration limit
    wait_idle();
    apb_write(REG_RELTOL, 33'd0);
    apb_write(REG_ABSEPS, 33'd0);
    random_traffic(2 * PHASE_ITEMS);

    // tolerances set to 1.0 in Q32.32
    wait_idle();
    apb_write(REG_RELTOL, 33'h1_0000_0000);
    apb_write(REG_ABSEPS, 33'h1_0000_0000);
    random_traffic(3 * PHASE_ITEMS);

    // small random tolerances
    wait_idle();
    apb_write(REG_RELTOL, 33'($urandom_range(0, 1 << 24)));
    apb_write(REG_ABSEPS, 33'($urandom_range(0, 1 << 12)));
    random_traffic(4 * PHASE_ITEMS);

    // fully random register contents
    wait_idle();
    apb_write(REG_RELTOL, {1'($urandom_range(0, 1)), 32'($urandom)});
    apb_write(REG_ABSEPS, {1'($urandom_range(0, 1)), 32'($urandom)});
    random_traffic(5 * PHASE_ITEMS);

    wait_idle();
    apb_write(REG_RELTOL, RELTOL_RESET);
    apb_write(REG_ABSEPS, ABSEPS_RESET);
    random_traffic(6 * PHASE_ITEMS);

    wait_idle();
    if (errors == 0) begin
      $display("brent_line_search_controller regression: pass");
    end else begin
      $display("brent_line_search_controller regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
